/* rtl/core/owcrc_pkg.sv */
// ----------------------------------------------------------------------------
// owcrc_pkg
// Constants and the byte-wide CRC-8 update for the 1-Wire frame checker.
// ----------------------------------------------------------------------------
package owcrc_pkg;

  // Reflected Dallas/Maxim CRC-8 polynomial
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Frame kinds
  localparam logic KIND_ROM = 1'b0;
  localparam logic KIND_PAD = 1'b1;

  // Frame lengths in bytes
  localparam logic [3:0] ROM_LEN         = 4'd8;
  localparam logic [3:0] PAD_LEN_CHECKED = 4'd9;
  localparam logic [3:0] PAD_LEN_SHORT   = 4'd2;

  // Bytes kept in the capture register
  localparam logic [3:0] CAPTURE_BYTES = 4'd8;

  // One byte through the CRC, bit 0 first
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc_in, input logic [7:0] data);
    logic [7:0] acc;
    acc = acc_in;
    for (int k = 0; k < 8; k++) begin
      if (acc[0] ^ data[k]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/core/onewire_frame_crc8_checker.sv */
// ----------------------------------------------------------------------------
// onewire_frame_crc8_checker
// Frames bytes read from a 1-Wire sensor, checks the CRC-8 and returns the
// ROM code or the raw Q12.4 temperature once per finished frame.
// ----------------------------------------------------------------------------
// Usage: one byte item is taken in every cycle in which in_valid is high and
// in_stall is low. A frame's result appears in the output register in the
// cycle after its last byte is taken and stays until taken (out_valid high,
// out_stall low). in_stall is only raised while a result waits and the sink
// stalls, so with a free-running sink the block sustains one byte per cycle;
// the CRC update of a whole byte and the frame bookkeeping fit between the
// frame state registers and the result register. ROM frames are 8 bytes,
// scratchpad frames 9 bytes (2 when cfg_wdata wrote check_enable as 0).
// A byte with in_frame_start abandons any open frame; a byte with no frame
// open is dropped. A check_enable write applies from the next byte taken,
// also inside an open frame; write it only while no byte is offered.
// ----------------------------------------------------------------------------
module onewire_frame_crc8_checker
  import owcrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_wdata,
  // byte items in
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  input  logic               in_frame_kind,
  // frame results out
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_done_kind,
  output logic               out_crc_good,
  output logic signed [15:0] out_temperature,
  output logic [63:0]        out_rom_code
);

  // Registers
  logic               check_enable_r;
  logic [7:0]         crc_acc_r, crc_acc_nxt;
  logic [3:0]         byte_count_r, byte_count_nxt;
  logic [63:0]        capture_r, capture_nxt;
  logic               kind_r, kind_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               done_kind_r;
  logic               crc_good_r;
  logic signed [15:0] temperature_r;
  logic [63:0]        rom_code_r;

  // Combinational work for one byte
  logic        in_accept, out_accept;
  logic        active;
  logic [7:0]  crc_base, crc_new;
  logic [3:0]  cnt_base, cnt_new;
  logic [63:0] cap_base, cap_new;
  logic        kind_eff;
  logic [3:0]  frame_len;
  logic        frame_end;
  logic        good;

  assign cfg_ready  = 1'b1;
  assign out_accept = out_valid_r & ~out_stall;
  assign in_stall   = out_valid_r & out_stall;
  assign in_accept  = in_valid & ~in_stall;

  // Frame step: start restarts from zero, otherwise continue the open frame
  always_comb begin
    if (in_frame_start) begin
      crc_base = 8'h00;
      cnt_base = 4'd0;
      cap_base = 64'd0;
      kind_eff = in_frame_kind;
    end else begin
      crc_base = crc_acc_r;
      cnt_base = byte_count_r;
      cap_base = capture_r;
      kind_eff = kind_r;
    end
    active  = in_frame_start | (byte_count_r != 4'd0);
    crc_new = crc8_byte(crc_base, in_rx_byte);
    cnt_new = cnt_base + 4'd1;

    // Capture the first eight bytes, byte 0 in the low lane
    cap_new = cap_base;
    if (cnt_base < CAPTURE_BYTES) begin
      cap_new[{cnt_base[2:0], 3'b000} +: 8] = in_rx_byte;
    end

    // Frame length follows the current check_enable on every byte
    if (kind_eff == KIND_PAD) begin
      frame_len = check_enable_r ? PAD_LEN_CHECKED : PAD_LEN_SHORT;
    end else begin
      frame_len = ROM_LEN;
    end
    frame_end = (cnt_new >= frame_len);
    good      = check_enable_r ? (crc_new == 8'h00) : 1'b1;
  end

  // Next frame state
  always_comb begin
    crc_acc_nxt    = crc_acc_r;
    byte_count_nxt = byte_count_r;
    capture_nxt    = capture_r;
    kind_nxt       = kind_r;
    if (in_accept && active) begin
      capture_nxt = cap_new;
      kind_nxt    = kind_eff;
      if (frame_end) begin
        crc_acc_nxt    = 8'h00;
        byte_count_nxt = 4'd0;
      end else begin
        crc_acc_nxt    = crc_new;
        byte_count_nxt = cnt_new;
      end
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept && active && frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_accept) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enable_r <= 1'b1;
      crc_acc_r      <= 8'h00;
      byte_count_r   <= 4'd0;
      kind_r         <= KIND_ROM;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        check_enable_r <= cfg_wdata;
      end
      crc_acc_r    <= crc_acc_nxt;
      byte_count_r <= byte_count_nxt;
      kind_r       <= kind_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: capture and result fields
  always_ff @(posedge clk) begin
    capture_r <= capture_nxt;
    if (in_accept && active && frame_end) begin
      done_kind_r   <= kind_eff;
      crc_good_r    <= good;
      temperature_r <= (kind_eff == KIND_PAD && good) ? $signed(cap_new[15:0]) : 16'sd0;
      rom_code_r    <= (kind_eff == KIND_ROM && good) ? cap_new : 64'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_done_kind   = done_kind_r;
  assign out_crc_good    = crc_good_r;
  assign out_temperature = temperature_r;
  assign out_rom_code    = rom_code_r;

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r < PAD_LEN_CHECKED)
    else $error("byte count past longest frame");

  a_idle_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_count_r == 4'd0) |-> (crc_acc_r == 8'h00))
    else $error("CRC not cleared with no frame open");

  a_temp_only_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && temperature_r != 16'sd0) |-> (done_kind_r == KIND_PAD && crc_good_r))
    else $error("temperature on ROM or bad frame");

  a_rom_only_rom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rom_code_r != 64'd0) |-> (done_kind_r == KIND_ROM && crc_good_r))
    else $error("ROM code on scratchpad or bad frame");

  a_orphan_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_frame_start && byte_count_r == 4'd0)
      |=> ($stable(byte_count_r) && $stable(crc_acc_r)))
    else $error("orphan byte changed frame state");

endmodule
